@@ sv/wildcard_pattern_matcher_macros.svh @@
// Assertion macros for the wildcard pattern matcher.
// Taken in by files that carry concurrent assertions; no other dependencies.
`ifndef WILDCARD_PATTERN_MATCHER_MACROS_SVH
`define WILDCARD_PATTERN_MATCHER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off while in reset.
`define WPM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("wildcard_pattern_matcher: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock, off while in reset.
`define WPM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("wildcard_pattern_matcher: next-cycle check failed");

`endif

@@ sv/wpm_pkg.sv @@
// Shared types, constants and helpers for the wildcard pattern matcher.
// No dependencies; used by wpm_decode, wpm_cell and the top level.
`default_nettype none

package wpm_pkg;

	localparam int PAT_WORDS  = 4;
	localparam int PAT_WORD_W = 64;
	localparam int PAT_BYTES  = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int LEN_W      = 6;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD_0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD_1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD_2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD_3 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_EXACT_CASE     = 3'd5;

	// Pattern symbols
	localparam logic [7:0] CHAR_STAR    = 8'h2A;
	localparam logic [7:0] CHAR_DOLLAR  = 8'h24;
	localparam logic [7:0] CHAR_CARET   = 8'h5E;
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
	localparam logic [7:0] CASE_OFFSET  = 8'h20;

	typedef logic [PAT_WORDS-1:0][PAT_WORD_W-1:0] wpm_words_t;

	// One body symbol as seen by a cell
	typedef struct packed {
		logic       used;   // position lies inside the pattern body
		logic       star;   // symbol is a wildcard run
		logic [7:0] lit;    // case-folded literal
	} wpm_sym_t;

	// Anchors stripped from the pattern
	typedef struct packed {
		logic anchor_start;
		logic anchor_end;
	} wpm_anchor_t;

	// Per-cycle control broadcast to the cell row
	typedef struct packed {
		logic text_start;   // this beat opens a new text
		logic advance;      // load the stepped position bit
		logic clear;        // text closes: drop all positions
	} wpm_ctl_t;

	function automatic logic [7:0] wpm_fold(input logic [7:0] c, input logic case_sens);
		if (!case_sens && c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
			return c + CASE_OFFSET;
		return c;
	endfunction

endpackage

`default_nettype wire

@@ sv/wpm_decode.sv @@
// Pattern decoder: strips the start and end anchors and hands one body
// symbol to each cell. Depends on wpm_pkg.
`default_nettype none

module wpm_decode #(
	parameter int PATTERN_MAX = 32,
	parameter int LW          = 6
) (
	input  wpm_pkg::wpm_words_t  words,
	input  logic [5:0]           pattern_length,
	input  logic                 exact_case,
	output wpm_pkg::wpm_sym_t    sym [PATTERN_MAX],
	output wpm_pkg::wpm_anchor_t anchors,
	output logic [LW-1:0]        body_len
);
	import wpm_pkg::*;

	logic [PAT_BYTES*8-1:0] flat;
	logic [LEN_W-1:0]       len;
	logic [LEN_W-1:0]       body_len_full;
	logic [7:0]             last_byte;
	logic                   a_start;
	logic                   a_end;

	assign flat = words;

	// Clamp the length to the number of cells
	assign len = (pattern_length > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : pattern_length;

	always_comb begin
		last_byte = '0;
		for (int k = 0; k < PATTERN_MAX; k++) begin
			if (len == LEN_W'(k + 1))
				last_byte = flat[8*k +: 8];
		end
	end

	assign a_start = (len != '0) && (flat[7:0] == CHAR_CARET);
	assign a_end   = (len > LEN_W'(a_start)) && (last_byte == CHAR_DOLLAR);

	assign body_len_full = len - LEN_W'(a_start) - LEN_W'(a_end);
	assign body_len      = body_len_full[LW-1:0];
	assign anchors       = '{anchor_start: a_start, anchor_end: a_end};

	for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_sym
		logic [7:0] src;
		if (k + 1 < PAT_BYTES) begin : g_shift
			assign src = a_start ? flat[8*(k+1) +: 8] : flat[8*k +: 8];
		end else begin : g_edge
			// last byte can only be body when there is no start anchor
			assign src = a_start ? 8'h00 : flat[8*k +: 8];
		end
		assign sym[k].used = LEN_W'(k) < body_len_full;
		assign sym[k].star = (src == CHAR_STAR);
		assign sym[k].lit  = wpm_fold(src, exact_case);
	end

endmodule

`default_nettype wire

@@ sv/wpm_cell.sv @@
// One position cell of the matcher row: holds one bit of the position
// vector and passes the step and closure carry to its right neighbor.
// Depends on wpm_pkg.
`default_nettype none

module wpm_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  wpm_pkg::wpm_ctl_t ctl,
	input  wpm_pkg::wpm_sym_t sym,
	input  logic [7:0]        fchar,
	input  logic              carry_in,
	input  logic              init_in,
	output logic              carry_out,
	output logic              init_out,
	output logic              pos_now,
	output logic              pos_next
);
	import wpm_pkg::*;

	logic pos_q;
	logic hit;

	assign pos_now  = ctl.text_start ? init_in : pos_q;
	assign hit      = pos_now & sym.used;

	// A star holds its own position; a literal that matches moves right.
	// A set star position also reaches the next one in the same cycle.
	assign pos_next  = (hit & sym.star) | carry_in;
	assign carry_out = (hit & ~sym.star & (sym.lit == fchar)) |
	                   (pos_next & sym.used & sym.star);
	assign init_out  = init_in & sym.used & sym.star;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 1'b0;
		end else if (ctl.clear) begin
			pos_q <= 1'b0;
		end else if (ctl.advance) begin
			pos_q <= pos_next;
		end
	end

endmodule

`default_nettype wire

@@ sv/wildcard_pattern_matcher.sv @@
// Wildcard pattern matcher top level: configuration registers, the cell row,
// the tail position, verdict logic and the output register.
// Depends on wpm_pkg, wpm_decode, wpm_cell and wildcard_pattern_matcher_macros.svh.
//
//   channel   direction  payload                                   handshake
//   s_*       in         tdata=text_char, tuser=char_present,      tvalid/tready
//                        tlast=end_of_text
//   m_*       out        tdata[0]=matched, one beat per text       tvalid/tready
//   cfg_*     in         index 0..5, data 64 bits                  cfg_we only
//
// One beat per clock unless stalled: the cell row steps the position vector and
// closes star runs in the same cycle, so the carry ripple through PATTERN_MAX cells
// sets the clock period. The verdict appears on m_tdata in the cycle after the
// tlast beat. Reset clears positions, configuration and the output register. While
// a verdict waits and m_tready is low, s_tready drops and every input beat stalls.
`default_nettype none
`include "wildcard_pattern_matcher_macros.svh"

module wildcard_pattern_matcher #(
	parameter int PATTERN_MAX = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	// text stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] text_char
	input  logic        s_tuser,   // [0] char_present
	input  logic        s_tlast,   // end_of_text
	// verdict stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata    // [0] matched, [7:1] zero
);
	import wpm_pkg::*;

	localparam int LW = $clog2(PATTERN_MAX + 1);

	// Configuration registers
	wpm_words_t       words_q;
	logic [LEN_W-1:0] pattern_length_q;
	logic             exact_case_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			words_q          <= '0;
			pattern_length_q <= '0;
			exact_case_q     <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PATTERN_WORD_0: words_q[0]       <= cfg_data;
				REG_PATTERN_WORD_1: words_q[1]       <= cfg_data;
				REG_PATTERN_WORD_2: words_q[2]       <= cfg_data;
				REG_PATTERN_WORD_3: words_q[3]       <= cfg_data;
				REG_PATTERN_LENGTH: pattern_length_q <= cfg_data[LEN_W-1:0];
				REG_EXACT_CASE:     exact_case_q     <= cfg_data[0];
				default: ;  // unmapped index: drop the write
			endcase
		end
	end

	// Pattern decode
	wpm_sym_t      sym [PATTERN_MAX];
	wpm_anchor_t   anchors;
	logic [LW-1:0] body_len;

	wpm_decode #(
		.PATTERN_MAX (PATTERN_MAX),
		.LW          (LW)
	) u_decode (
		.words          (words_q),
		.pattern_length (pattern_length_q),
		.exact_case     (exact_case_q),
		.sym            (sym),
		.anchors        (anchors),
		.body_len       (body_len)
	);

	// Handshake and per-beat control
	logic     m_tvalid_q;
	logic     matched_q;
	logic     text_start_q;
	logic     match_seen_q;
	logic     tail_q;
	logic     take;
	logic     step;
	logic     close;
	wpm_ctl_t ctl;

	assign s_tready = ~m_tvalid_q | m_tready;
	assign take     = s_tvalid & s_tready;
	// A beat with no character that does not close the text changes nothing
	assign step     = take & (s_tuser | s_tlast);
	assign close    = step & s_tlast;

	assign ctl = '{text_start: text_start_q,
	               advance:    step & s_tuser & ~s_tlast,
	               clear:      close};

	// Cell row
	logic [7:0]             fchar;
	logic [PATTERN_MAX:0]   carry;
	logic [PATTERN_MAX:0]   init;
	logic [PATTERN_MAX:0]   pos_now;
	logic [PATTERN_MAX:0]   pos_next;

	assign fchar    = wpm_fold(s_tdata, exact_case_q);
	// Without a start anchor, position zero is re-entered on every character
	assign carry[0] = ~anchors.anchor_start;
	assign init[0]  = 1'b1;

	for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
		wpm_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.sym       (sym[k]),
			.fchar     (fchar),
			.carry_in  (carry[k]),
			.init_in   (init[k]),
			.carry_out (carry[k+1]),
			.init_out  (init[k+1]),
			.pos_now   (pos_now[k]),
			.pos_next  (pos_next[k])
		);
	end

	// Tail position, reached only when the body is full length
	assign pos_now[PATTERN_MAX]  = text_start_q ? init[PATTERN_MAX] : tail_q;
	assign pos_next[PATTERN_MAX] = carry[PATTERN_MAX];

	// Verdict: with an end anchor the final position must hold at the close,
	// otherwise the body must have been completed at any point of the text
	logic seen_base;
	logic seen_after;
	logic full_now;
	logic full_next;
	logic matched_d;

	assign full_now   = pos_now[body_len];
	assign full_next  = pos_next[body_len];
	assign seen_base  = (~text_start_q & match_seen_q) | (~anchors.anchor_end & full_now);
	assign seen_after = seen_base | (s_tuser & ~anchors.anchor_end & full_next);
	assign matched_d  = anchors.anchor_end ? (s_tuser ? full_next : full_now) : seen_after;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_start_q <= 1'b1;
			match_seen_q <= 1'b0;
			tail_q       <= 1'b0;
		end else if (close) begin
			text_start_q <= 1'b1;
			match_seen_q <= 1'b0;
			tail_q       <= 1'b0;
		end else if (ctl.advance) begin
			text_start_q <= 1'b0;
			match_seen_q <= seen_after;
			tail_q       <= pos_next[PATTERN_MAX];
		end
	end

	// Output register: load on a closing beat, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (close) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			matched_q <= 1'b0;
		end else if (close) begin
			matched_q <= matched_d;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {7'b0, matched_q};

	// Checks
	`WPM_ASSERT_NEXT(a_close_gives_verdict, clk, arst_n, close, m_tvalid)
	`WPM_ASSERT_NEXT(a_close_rearms, clk, arst_n, close, text_start_q && (pos_now == init) && !tail_q)
	`WPM_ASSERT_NOW(a_stall_only_on_full_output, clk, arst_n, !s_tready, m_tvalid_q && !m_tready)

endmodule

`default_nettype wire
